// ===== sv/cft_pkg.sv =====
// Package with types, codes and elaboration-time group tables for the Clifford frame tracker.
`timescale 1ns / 1ps
package cft_pkg;

  localparam int NGROUP  = 24;
  localparam int MAXWORD = 8;

  // Instruction and result codes.
  localparam logic [1:0] OP_GATE1 = 2'd0;
  localparam logic [1:0] OP_GATE2 = 2'd1;
  localparam logic [1:0] OP_MEAS  = 2'd2;
  localparam logic [1:0] OP_FLUSH = 2'd3;

  localparam logic [1:0] KIND_GATE1 = 2'd0;
  localparam logic [1:0] KIND_GATE2 = 2'd1;
  localparam logic [1:0] KIND_MEAS  = 2'd2;

  localparam logic [2:0] GATE_H   = 3'd0;
  localparam logic [2:0] GATE_S   = 3'd1;
  localparam logic [2:0] GATE_X   = 3'd3;
  localparam logic [2:0] GATE_LAST1 = 3'd5;
  localparam logic [2:0] GATE_CZ  = 3'd6;
  localparam logic [2:0] GATE_CX  = 3'd7;

  localparam logic [1:0] BASIS_Z    = 2'd2;
  localparam logic [1:0] BASIS_BAD  = 2'd3;
  localparam logic [1:0] CAND_CZ    = 2'd0;
  localparam logic [1:0] CAND_CX_BA = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_FACT, ST_DUMPA, ST_DUMPB, ST_GATE, ST_WRB
  } eng_state_t;

  typedef struct packed {
    logic [1:0] ph;
    logic       x;
    logic       z;
  } pauli_t;

  typedef struct packed {
    pauli_t xi;
    pauli_t zi;
  } cliff_t;

  typedef struct packed {
    logic [1:0] ph;
    logic       x0;
    logic       z0;
    logic       x1;
    logic       z1;
  } pp_t;

  typedef pp_t [3:0] tab_t;

  typedef struct packed {
    cliff_t [NGROUP-1:0]                    el;
    logic [NGROUP-1:0][3:0]                 len;
    logic [NGROUP-1:0][MAXWORD-1:0][2:0]    word;
  } grp_info_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] cand;
    logic [4:0] na;
    logic [4:0] nb;
  } fact_t;

  typedef struct packed {
    logic [1:0] basis;
    logic       minus;
  } meas_t;

  typedef logic [NGROUP-1:0][5:0][4:0]           gmul_tab_t;
  typedef fact_t [NGROUP-1:0][NGROUP-1:0][1:0]   fact_tab_t;
  typedef meas_t [NGROUP-1:0][2:0]               meas_tab_t;

  // Images of +X, +Y, +Z under each one-qubit gate, as {phase, x, z}.
  localparam logic [3:0] GATE_CONJ [6][3] = '{
    '{4'b0001, 4'b1111, 4'b0010},
    '{4'b0111, 4'b1010, 4'b0001},
    '{4'b1111, 4'b0010, 4'b0001},
    '{4'b0010, 4'b1111, 4'b1001},
    '{4'b1010, 4'b0111, 4'b1001},
    '{4'b1010, 4'b1111, 4'b0001}
  };

  function automatic pauli_t conj1(int g, pauli_t s);
    pauli_t r;
    int p;
    logic [1:0] intr;
    r = s;
    if (s.x || s.z) begin
      if (s.x && !s.z) begin
        p = 0; intr = 2'd0;
      end else if (!s.x && s.z) begin
        p = 2; intr = 2'd0;
      end else begin
        p = 1; intr = 2'd1;
      end
      r = GATE_CONJ[g][p];
      r.ph = r.ph + s.ph - intr;
    end
    return r;
  endfunction

  function automatic cliff_t apply_gate(cliff_t f, int g);
    cliff_t r;
    r.xi = conj1(g, f.xi);
    r.zi = conj1(g, f.zi);
    return r;
  endfunction

  function automatic int find_cliff(cliff_t [NGROUP-1:0] el, int count, cliff_t f);
    int res;
    res = -1;
    for (int i = NGROUP - 1; i >= 0; i--) begin
      if (i < count && el[i] == f) res = i;
    end
    return res;
  endfunction

  function automatic logic [2:0] gen_code(int j);
    logic [2:0] c;
    case (j)
      0: c = GATE_H;
      1: c = GATE_S;
      default: c = GATE_X;
    endcase
    return c;
  endfunction

  // Breadth-first enumeration of the group with shortest H/S/X words.
  function automatic grp_info_t build_group();
    grp_info_t gi;
    cliff_t nf;
    int count;
    gi = '0;
    gi.el[0].xi.x = 1'b1;
    gi.el[0].zi.z = 1'b1;
    count = 1;
    for (int head = 0; head < NGROUP; head++) begin
      if (head < count) begin
        for (int j = 0; j < 3; j++) begin
          nf = apply_gate(gi.el[head], int'(gen_code(j)));
          if (count < NGROUP && find_cliff(gi.el, count, nf) < 0 &&
              int'(gi.len[head]) < MAXWORD) begin
            gi.el[count] = nf;
            gi.word[count] = gi.word[head];
            gi.word[count][gi.len[head]] = gen_code(j);
            gi.len[count] = gi.len[head] + 4'd1;
            count++;
          end
        end
      end
    end
    return gi;
  endfunction

  function automatic gmul_tab_t build_gmul(grp_info_t gi);
    gmul_tab_t t;
    int idx;
    t = '0;
    for (int i = 0; i < NGROUP; i++) begin
      for (int j = 0; j < 6; j++) begin
        idx = find_cliff(gi.el, NGROUP, apply_gate(gi.el[i], j));
        t[i][j] = (idx < 0) ? 5'd0 : 5'(idx);
      end
    end
    return t;
  endfunction

  function automatic pp_t pp_mul(pp_t a, pp_t b);
    pp_t r;
    r.ph = a.ph + b.ph + {((a.z0 & b.x0) ^ (a.z1 & b.x1)), 1'b0};
    r.x0 = a.x0 ^ b.x0;
    r.z0 = a.z0 ^ b.z0;
    r.x1 = a.x1 ^ b.x1;
    r.z1 = a.z1 ^ b.z1;
    return r;
  endfunction

  function automatic pp_t pp_unit(int gidx);
    pp_t r;
    r = '0;
    case (gidx)
      0: r.x0 = 1'b1;
      1: r.z0 = 1'b1;
      2: r.x1 = 1'b1;
      default: r.z1 = 1'b1;
    endcase
    return r;
  endfunction

  function automatic tab_t entangler_tab(int kind, int c, int t);
    tab_t r;
    for (int i = 0; i < 4; i++) r[i] = pp_unit(i);
    if (kind == 0) begin
      r[0].z1 = 1'b1;
      r[2].z0 = 1'b1;
    end else begin
      r[2*c]   = pp_mul(pp_unit(2*c), pp_unit(2*t));
      r[2*t+1] = pp_mul(pp_unit(2*c+1), pp_unit(2*t+1));
    end
    return r;
  endfunction

  function automatic tab_t frame_pair_tab(cliff_t a, cliff_t b);
    tab_t r;
    r = '0;
    r[0].ph = a.xi.ph; r[0].x0 = a.xi.x; r[0].z0 = a.xi.z;
    r[1].ph = a.zi.ph; r[1].x0 = a.zi.x; r[1].z0 = a.zi.z;
    r[2].ph = b.xi.ph; r[2].x1 = b.xi.x; r[2].z1 = b.xi.z;
    r[3].ph = b.zi.ph; r[3].x1 = b.zi.x; r[3].z1 = b.zi.z;
    return r;
  endfunction

  function automatic pp_t tab_apply(tab_t u, pp_t s);
    pp_t acc;
    acc = '0;
    acc.ph = s.ph;
    if (s.x0) acc = pp_mul(acc, u[0]);
    if (s.z0) acc = pp_mul(acc, u[1]);
    if (s.x1) acc = pp_mul(acc, u[2]);
    if (s.z1) acc = pp_mul(acc, u[3]);
    return acc;
  endfunction

  function automatic tab_t tab_compose(tab_t u, tab_t v);
    tab_t r;
    for (int i = 0; i < 4; i++) r[i] = tab_apply(u, v[i]);
    return r;
  endfunction

  // Factor G o (Fa x Fb) as (Fa' x Fb') o G' for bare CZ, CX(a,b), CX(b,a).
  function automatic fact_t factor_gate(grp_info_t gi, int gk, int fa, int fb);
    fact_t res;
    tab_t lt;
    tab_t m;
    cliff_t ca;
    cliff_t cb;
    int ia;
    int ib;
    int kind;
    int c;
    int t;
    res = '0;
    lt = tab_compose(entangler_tab(gk, 0, 1), frame_pair_tab(gi.el[fa], gi.el[fb]));
    for (int k = 2; k >= 0; k--) begin
      kind = (k == 0) ? 0 : 1;
      c = (k == 2) ? 1 : 0;
      t = (k == 2) ? 0 : 1;
      m = tab_compose(lt, entangler_tab(kind, c, t));
      if (!(m[0].x1 | m[0].z1 | m[1].x1 | m[1].z1 |
            m[2].x0 | m[2].z0 | m[3].x0 | m[3].z0)) begin
        ca.xi.ph = m[0].ph; ca.xi.x = m[0].x0; ca.xi.z = m[0].z0;
        ca.zi.ph = m[1].ph; ca.zi.x = m[1].x0; ca.zi.z = m[1].z0;
        cb.xi.ph = m[2].ph; cb.xi.x = m[2].x1; cb.xi.z = m[2].z1;
        cb.zi.ph = m[3].ph; cb.zi.x = m[3].x1; cb.zi.z = m[3].z1;
        ia = find_cliff(gi.el, NGROUP, ca);
        ib = find_cliff(gi.el, NGROUP, cb);
        // Lower candidates are visited last and overwrite, so the lowest candidate that succeeds wins.
        if (ia >= 0 && ib >= 0) begin
          res.ok = 1'b1;
          res.cand = 2'(k);
          res.na = 5'(ia);
          res.nb = 5'(ib);
        end
      end
    end
    return res;
  endfunction

  function automatic fact_tab_t build_fact(grp_info_t gi);
    fact_tab_t t;
    for (int a = 0; a < NGROUP; a++)
      for (int b = 0; b < NGROUP; b++)
        for (int g = 0; g < 2; g++)
          t[a][b][g] = factor_gate(gi, g, a, b);
    return t;
  endfunction

  // Measurement basis rewrite: the first frame image that lands on the asked basis.
  function automatic meas_tab_t build_meas(grp_info_t gi);
    meas_tab_t t;
    cliff_t f;
    pauli_t s;
    logic [1:0] bi;
    logic mn;
    logic found;
    for (int i = 0; i < NGROUP; i++) begin
      f = gi.el[i];
      for (int pb = 0; pb < 3; pb++) begin
        t[i][pb].basis = 2'(pb);
        t[i][pb].minus = 1'b0;
        found = 1'b0;
        for (int q = 0; q < 3; q++) begin
          if (q == 0) s = f.xi;
          else if (q == 2) s = f.zi;
          else begin
            s.ph = f.xi.ph + f.zi.ph + {(f.xi.z & f.zi.x), 1'b0} + 2'd1;
            s.x = f.xi.x ^ f.zi.x;
            s.z = f.xi.z ^ f.zi.z;
          end
          if (s.x && s.z) begin
            bi = 2'd1; mn = (s.ph == 2'd3);
          end else begin
            bi = s.x ? 2'd0 : 2'd2; mn = (s.ph == 2'd2);
          end
          if (!found && int'(bi) == pb) begin
            found = 1'b1;
            t[i][pb].basis = 2'(q);
            t[i][pb].minus = mn;
          end
        end
      end
    end
    return t;
  endfunction

  localparam grp_info_t GRP  = build_group();
  localparam gmul_tab_t GMUL = build_gmul(GRP);
  localparam fact_tab_t FACT = build_fact(GRP);
  localparam meas_tab_t MEAS = build_meas(GRP);

endpackage

// ===== sv/cft_frame_mem.sv =====
// Frame store: one write port and two registered read ports.
`timescale 1ns / 1ps
module cft_frame_mem
  import cft_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          re,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [4:0]    wdata,
  output logic [4:0]    rdata_a,
  output logic [4:0]    rdata_b
);

  logic [4:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // Read ports hold their data until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== sv/clifford_frame_tracker.sv =====
// Top level of the Clifford frame tracker: input buffer, sequencer and output register.
`timescale 1ns / 1ps
// Each qubit keeps a pending one-qubit Clifford frame in an on-chip frame store.
// Input words (opcode, wires, gate, basis, flip) arrive on in_valid/in_stall;
// result words leave on out_valid/out_stall with last on the final word of an item.
// A one-entry input buffer takes a word while the sequencer works on the one before.
// The frame store has a single write port and result words leave one at a time.
// A measurement emits its word from the read state; a gate that factors emits it from
// the factoring state, after the registered table lookup. A flush emits the frame word
// of its wire from the first dump state; a gate that does not factor emits both frame
// words from the dump states, then the gate itself.
// After reset the frame store is cleared to identity, one entry per cycle, for all
// NUM_QUBITS entries; in_stall stays high during that pass.
// When the receiver stalls, the output register holds its word and the sequencer
// waits; the input buffer fills and in_stall rises.
// Items with a wire out of range or an opcode and gate mismatch are dropped.
module clifford_frame_tracker
  import cft_pkg::*;
#(
  parameter int NUM_QUBITS = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] opcode,
  input  logic [7:0] wire_a,
  input  logic [7:0] wire_b,
  input  logic [2:0] gate_code,
  input  logic [1:0] read_basis,
  input  logic       read_flip,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] emit_kind,
  output logic [2:0] emit_gate,
  output logic [7:0] emit_wire_a,
  output logic [7:0] emit_wire_b,
  output logic [1:0] emit_basis,
  output logic       emit_flip,
  output logic       last
);

  localparam int AW = (NUM_QUBITS > 1) ? $clog2(NUM_QUBITS) : 1;
  localparam logic [AW-1:0] CLR_LAST = AW'(NUM_QUBITS - 1);

  eng_state_t state, state_next;

  // Input buffer.
  logic       ib_valid;
  logic [1:0] ib_op;
  logic [7:0] ib_wa, ib_wb;
  logic [2:0] ib_gc;
  logic [1:0] ib_rb;
  logic       ib_rf;

  // Item under work.
  logic [1:0] op;
  logic [7:0] wa, wb;
  logic [2:0] gc;
  logic [1:0] rb;
  logic       rf;

  logic [AW-1:0] clr_cnt;
  logic [3:0]    di, di_next;
  fact_t         fact_q;

  logic       take, item_ok;
  logic       out_free;
  logic [4:0] rd_a, rd_b;
  logic [4:0] fa, fb, fbd;
  logic [3:0] len_a, len_b;
  logic       more_a, more_b;
  logic [1:0] pb;

  logic       we;
  logic [AW-1:0] waddr;
  logic [4:0] wdata;

  logic       ev;
  logic [1:0] ev_kind;
  logic [2:0] ev_gate;
  logic [7:0] ev_wa, ev_wb;
  logic [1:0] ev_basis;
  logic       ev_flip, ev_last;

  assign in_stall = ib_valid || (state == ST_CLEAR);
  assign take     = ib_valid && (state == ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Items that touch a wire out of range or mix opcode and gate are dropped.
  always_comb begin
    item_ok = (32'(ib_wa) < NUM_QUBITS);
    case (ib_op)
      OP_GATE1: item_ok = item_ok && (ib_gc <= GATE_LAST1);
      OP_GATE2: item_ok = item_ok && (ib_gc >= GATE_CZ) && (32'(ib_wb) < NUM_QUBITS);
      default:  item_ok = item_ok;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ib_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      ib_valid <= 1'b1;
    end else if (take) begin
      ib_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ib_op <= opcode;
      ib_wa <= wire_a;
      ib_wb <= wire_b;
      ib_gc <= gate_code;
      ib_rb <= read_basis;
      ib_rf <= read_flip;
    end
    if (take) begin
      op <= ib_op;
      wa <= ib_wa;
      wb <= ib_wb;
      gc <= ib_gc;
      rb <= ib_rb;
      rf <= ib_rf;
    end
  end

  cft_frame_mem #(
    .DEPTH (NUM_QUBITS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .re      (take),
    .raddr_a (AW'(ib_wa)),
    .raddr_b (AW'(ib_wb)),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // Frame decode; when both wires of a gate are the same, the second dump sees identity.
  always_comb begin
    fa     = (rd_a < 5'(NGROUP)) ? rd_a : 5'd0;
    fb     = (rd_b < 5'(NGROUP)) ? rd_b : 5'd0;
    fbd    = (wa == wb) ? 5'd0 : fb;
    len_a  = GRP.len[fa];
    len_b  = GRP.len[fbd];
    more_a = di < len_a;
    more_b = di < len_b;
    pb     = (rb == BASIS_BAD) ? BASIS_Z : rb;
  end

  // Next state.
  always_comb begin
    state_next = state;
    di_next    = di;
    case (state)
      ST_CLEAR: if (clr_cnt == CLR_LAST) state_next = ST_IDLE;
      ST_IDLE:  if (take && item_ok) state_next = ST_READ;
      ST_READ: begin
        di_next = 4'd0;
        case (op)
          OP_GATE1: state_next = ST_IDLE;
          OP_GATE2: state_next = ST_FACT;
          OP_MEAS:  if (out_free) state_next = ST_IDLE;
          default:  state_next = ST_DUMPA;
        endcase
      end
      ST_FACT: begin
        if (!fact_q.ok) state_next = ST_DUMPA;
        else if (out_free) state_next = ST_WRB;
      end
      ST_DUMPA: begin
        if (!more_a) begin
          di_next    = 4'd0;
          state_next = (op == OP_FLUSH) ? ST_IDLE : ST_DUMPB;
        end else if (out_free) begin
          di_next = di + 4'd1;
        end
      end
      ST_DUMPB: begin
        if (!more_b) state_next = ST_GATE;
        else if (out_free) di_next = di + 4'd1;
      end
      ST_GATE: if (out_free) state_next = ST_IDLE;
      ST_WRB:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Frame store writes and result words for each state.
  always_comb begin
    we       = 1'b0;
    waddr    = AW'(wa);
    wdata    = 5'd0;
    ev       = 1'b0;
    ev_kind  = KIND_GATE1;
    ev_gate  = 3'd0;
    ev_wa    = wa;
    ev_wb    = 8'd0;
    ev_basis = 2'd0;
    ev_flip  = 1'b0;
    ev_last  = 1'b0;
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt;
      end
      ST_READ: begin
        case (op)
          OP_GATE1: begin
            we    = 1'b1;
            wdata = GMUL[fa][gc];
          end
          OP_MEAS: begin
            if (out_free) begin
              we       = 1'b1;
              ev       = 1'b1;
              ev_kind  = KIND_MEAS;
              ev_basis = MEAS[fa][pb].basis;
              ev_flip  = rf ^ MEAS[fa][pb].minus;
              ev_last  = 1'b1;
            end
          end
          OP_FLUSH: we = 1'b1;
          default:  we = 1'b0;
        endcase
      end
      ST_FACT: begin
        if (!fact_q.ok) begin
          we = 1'b1;
        end else if (out_free) begin
          we      = 1'b1;
          wdata   = fact_q.na;
          ev      = 1'b1;
          ev_kind = KIND_GATE2;
          ev_gate = (fact_q.cand == CAND_CZ) ? GATE_CZ : GATE_CX;
          ev_wa   = (fact_q.cand == CAND_CX_BA) ? wb : wa;
          ev_wb   = (fact_q.cand == CAND_CX_BA) ? wa : wb;
          ev_last = 1'b1;
        end
      end
      ST_DUMPA: begin
        if (more_a && out_free) begin
          ev      = 1'b1;
          ev_gate = GRP.word[fa][di[2:0]];
          ev_last = (op == OP_FLUSH) && (di == len_a - 4'd1);
        end
      end
      ST_DUMPB: begin
        if (more_b && out_free) begin
          ev      = 1'b1;
          ev_gate = GRP.word[fbd][di[2:0]];
          ev_wa   = wb;
        end
      end
      ST_GATE: begin
        if (out_free) begin
          we      = 1'b1;
          waddr   = AW'(wb);
          ev      = 1'b1;
          ev_kind = KIND_GATE2;
          ev_gate = gc;
          ev_wb   = wb;
          ev_last = 1'b1;
        end
      end
      ST_WRB: begin
        we    = 1'b1;
        waddr = AW'(wb);
        wdata = fact_q.nb;
      end
      default: we = 1'b0;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      di      <= 4'd0;
    end else begin
      state <= state_next;
      di    <= di_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Factoring table lookup, registered ahead of the emit step.
  always_ff @(posedge clk) begin
    if (state == ST_READ) fact_q <= FACT[fa][fb][gc[0]];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= ev;
    end
  end

  always_ff @(posedge clk) begin
    if (ev) begin
      emit_kind   <= ev_kind;
      emit_gate   <= ev_gate;
      emit_wire_a <= ev_wa;
      emit_wire_b <= ev_wb;
      emit_basis  <= ev_basis;
      emit_flip   <= ev_flip;
      last        <= ev_last;
    end
  end

endmodule

// ===== sv/cft_checker.sv =====
// Port-level checker for the Clifford frame tracker, bound to the top level.
`timescale 1ns / 1ps
module cft_checker
  import cft_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] emit_kind,
  input logic [2:0] emit_gate,
  input logic       last
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped under stall");

  // A measurement is always the only and final word of its item.
  a_meas_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && emit_kind == KIND_MEAS |-> last)
    else $error("measurement word not marked last");

  // A two-qubit gate closes its item and is always CZ or CX.
  a_gate2_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && emit_kind == KIND_GATE2 |-> last &&
      (emit_gate == GATE_CZ || emit_gate == GATE_CX))
    else $error("two-qubit word malformed");

  // Nothing leaves in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result word right after reset");

endmodule

bind clifford_frame_tracker cft_checker u_cft_checker (.*);

// ===== tb/clifford_frame_tracker_check.sv =====
// Checker for the Clifford frame tracker: watches both channels, predicts result words, compares.
`timescale 1ns / 1ps
module clifford_frame_tracker_check
  import cft_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] opcode,
  input  logic [7:0] wire_a,
  input  logic [7:0] wire_b,
  input  logic [2:0] gate_code,
  input  logic [1:0] read_basis,
  input  logic       read_flip,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] emit_kind,
  input  logic [2:0] emit_gate,
  input  logic [7:0] emit_wire_a,
  input  logic [7:0] emit_wire_b,
  input  logic [1:0] emit_basis,
  input  logic       emit_flip,
  input  logic       last,
  output int         fail_count,
  output int         words_owed
);

  localparam int GROUP_SIZE = 24;

  // A signed Pauli is {phase[1:0], x, z}; a frame holds the images of X and Z.
  typedef logic [3:0] spauli_t;
  typedef struct packed {
    spauli_t img_x;
    spauli_t img_z;
  } frame_t;

  // Two-qubit signed Pauli and a two-qubit tableau (images of X0, Z0, X1, Z1).
  typedef struct packed {
    logic [1:0] ph;
    logic       x0;
    logic       z0;
    logic       x1;
    logic       z1;
  } pair_pauli_t;
  typedef pair_pauli_t [3:0] pair_tab_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] gate;
    logic [7:0] wa;
    logic [7:0] wb;
    logic [1:0] basis;
    logic       flip;
    logic       lst;
  } result_word_t;

  frame_t     elem [GROUP_SIZE];
  int         word_len [GROUP_SIZE];
  logic [2:0] word_gate [GROUP_SIZE][8];
  logic [4:0] fold_tab [GROUP_SIZE][6];
  logic [4:0] frame_mirror [256];
  result_word_t owed_words [$];

  // Image of X, Y or Z (index 0, 1, 2) under a one-qubit gate.
  function automatic spauli_t gate_image(int g, int axis);
    logic [3:0] row [3];
    case (g)
      0: row = '{4'd1, 4'd15, 4'd2};
      1: row = '{4'd7, 4'd10, 4'd1};
      2: row = '{4'd15, 4'd2, 4'd1};
      3: row = '{4'd2, 4'd15, 4'd9};
      4: row = '{4'd10, 4'd7, 4'd9};
      default: row = '{4'd10, 4'd15, 4'd1};
    endcase
    return row[axis];
  endfunction

  function automatic spauli_t conj_pauli(int g, spauli_t s);
    spauli_t r;
    int axis;
    logic [1:0] shift;
    if (!s[1] && !s[0]) return s;
    if (s[1] && s[0]) begin
      axis = 1; shift = 2'd1;
    end else begin
      axis = s[1] ? 0 : 2; shift = 2'd0;
    end
    r = gate_image(g, axis);
    r[3:2] = r[3:2] + s[3:2] - shift;
    return r;
  endfunction

  function automatic frame_t fold_gate(frame_t f, int g);
    frame_t r;
    r.img_x = conj_pauli(g, f.img_x);
    r.img_z = conj_pauli(g, f.img_z);
    return r;
  endfunction

  function automatic int lookup_frame(frame_t f, int count);
    for (int i = 0; i < count; i++) if (elem[i] == f) return i;
    return -1;
  endfunction

  function automatic pair_pauli_t pp_times(pair_pauli_t a, pair_pauli_t b);
    pair_pauli_t r;
    r.ph = a.ph + b.ph + {((a.z0 & b.x0) ^ (a.z1 & b.x1)), 1'b0};
    r.x0 = a.x0 ^ b.x0; r.z0 = a.z0 ^ b.z0;
    r.x1 = a.x1 ^ b.x1; r.z1 = a.z1 ^ b.z1;
    return r;
  endfunction

  function automatic pair_pauli_t pp_gen(int i);
    pair_pauli_t r;
    r = '0;
    r.x0 = (i == 0); r.z0 = (i == 1); r.x1 = (i == 2); r.z1 = (i == 3);
    return r;
  endfunction

  // Bare entangler: kind 0 is CZ, kind 1 is CX with control c and target t.
  function automatic pair_tab_t entangler(int kind, int c, int t);
    pair_tab_t r;
    for (int i = 0; i < 4; i++) r[i] = pp_gen(i);
    if (kind == 0) begin
      r[0].z1 = 1'b1;
      r[2].z0 = 1'b1;
    end else begin
      r[2*c]   = pp_times(pp_gen(2*c), pp_gen(2*t));
      r[2*t+1] = pp_times(pp_gen(2*c+1), pp_gen(2*t+1));
    end
    return r;
  endfunction

  function automatic pair_pauli_t tab_map(pair_tab_t u, pair_pauli_t s);
    pair_pauli_t acc;
    acc = '0;
    acc.ph = s.ph;
    if (s.x0) acc = pp_times(acc, u[0]);
    if (s.z0) acc = pp_times(acc, u[1]);
    if (s.x1) acc = pp_times(acc, u[2]);
    if (s.z1) acc = pp_times(acc, u[3]);
    return acc;
  endfunction

  // Tries to rewrite G o (Fa x Fb) as (Fa' x Fb') o G' with G' a bare CZ, CX(a,b), CX(b,a).
  function automatic logic try_commute(int gk, int fa, int fb,
                                       output int cand, output int na, output int nb);
    pair_tab_t lt, bt, m, prod;
    frame_t ca, cb;
    int ia, ib;
    prod = '0;
    prod[0] = {elem[fa].img_x, 2'b00};
    prod[1] = {elem[fa].img_z, 2'b00};
    prod[2] = {elem[fb].img_x[3:2], 2'b00, elem[fb].img_x[1:0]};
    prod[3] = {elem[fb].img_z[3:2], 2'b00, elem[fb].img_z[1:0]};
    bt = entangler(gk, 0, 1);
    for (int i = 0; i < 4; i++) lt[i] = tab_map(bt, prod[i]);
    cand = 0; na = 0; nb = 0;
    for (int k = 0; k < 3; k++) begin
      bt = entangler(k == 0 ? 0 : 1, k == 2 ? 1 : 0, k == 2 ? 0 : 1);
      for (int i = 0; i < 4; i++) m[i] = tab_map(lt, bt[i]);
      if (m[0].x1 | m[0].z1 | m[1].x1 | m[1].z1 | m[2].x0 | m[2].z0 | m[3].x0 | m[3].z0)
        continue;
      ca.img_x = {m[0].ph, m[0].x0, m[0].z0};
      ca.img_z = {m[1].ph, m[1].x0, m[1].z0};
      cb.img_x = {m[2].ph, m[2].x1, m[2].z1};
      cb.img_z = {m[3].ph, m[3].x1, m[3].z1};
      ia = lookup_frame(ca, GROUP_SIZE);
      ib = lookup_frame(cb, GROUP_SIZE);
      if (ia < 0 || ib < 0) continue;
      cand = k; na = ia; nb = ib;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_word_t mk_word(logic [1:0] kind, logic [2:0] gate,
                                           logic [7:0] wa, logic [7:0] wb,
                                           logic [1:0] basis, logic flip);
    result_word_t w;
    w = '{kind, gate, wa, wb, basis, flip, 1'b0};
    return w;
  endfunction

  // Emits the shortest H/S/X word of a qubit's frame and resets it to identity.
  function automatic void flush_frame(logic [7:0] q, ref result_word_t ws [$]);
    int f;
    f = frame_mirror[q];
    for (int i = 0; i < word_len[f]; i++)
      ws = {ws, mk_word(KIND_GATE1, word_gate[f][i], q, 8'd0, 2'd0, 1'b0)};
    frame_mirror[q] = 5'd0;
  endfunction

  function automatic void predict_item(logic [1:0] op, logic [7:0] a, logic [7:0] b,
                                       logic [2:0] g, logic [1:0] rb, logic rf);
    result_word_t ws [$];
    int cand, na, nb, pb, nq;
    logic minus, mn;
    int bi;
    frame_t f;
    spauli_t s;
    if (op == OP_GATE1) begin
      if (g <= GATE_LAST1) frame_mirror[a] = fold_tab[frame_mirror[a]][g];
      return;
    end
    if (op == OP_GATE2) begin
      if (g < GATE_CZ) return;
      if (try_commute(g - GATE_CZ, frame_mirror[a], frame_mirror[b], cand, na, nb)) begin
        if (cand == 2) ws = {ws, mk_word(KIND_GATE2, GATE_CX, b, a, 2'd0, 1'b0)};
        else ws = {ws, mk_word(KIND_GATE2, cand == 0 ? GATE_CZ : GATE_CX, a, b,
                               2'd0, 1'b0)};
        frame_mirror[a] = 5'(na);
        frame_mirror[b] = 5'(nb);
      end else begin
        flush_frame(a, ws);
        flush_frame(b, ws);
        ws = {ws, mk_word(KIND_GATE2, g, a, b, 2'd0, 1'b0)};
      end
    end else if (op == OP_MEAS) begin
      // Find which frame image lands on the asked basis; its sign inverts the record.
      pb = (rb == BASIS_BAD) ? 2 : int'(rb);
      nq = pb;
      minus = 1'b0;
      f = elem[frame_mirror[a]];
      for (int q = 0; q < 3; q++) begin
        if (q == 0) s = f.img_x;
        else if (q == 2) s = f.img_z;
        else begin
          s[3:2] = f.img_x[3:2] + f.img_z[3:2] + {(f.img_x[0] & f.img_z[1]), 1'b0} + 2'd1;
          s[1] = f.img_x[1] ^ f.img_z[1];
          s[0] = f.img_x[0] ^ f.img_z[0];
        end
        if (s[1] && s[0]) begin
          bi = 1; mn = (s[3:2] == 2'd3);
        end else begin
          bi = s[1] ? 0 : 2; mn = (s[3:2] == 2'd2);
        end
        if (bi == pb) begin
          nq = q; minus = mn;
          break;
        end
      end
      frame_mirror[a] = 5'd0;
      ws = {ws, mk_word(KIND_MEAS, 3'd0, a, 8'd0, 2'(nq), rf ^ minus)};
    end else begin
      flush_frame(a, ws);
    end
    if (ws.size() > 0) ws[ws.size()-1].lst = 1'b1;
    owed_words = {owed_words, ws};
  endfunction

  // Build the group by breadth-first search over H, S, X, then the fold table.
  initial begin
    int count;
    frame_t nf;
    logic [2:0] gens [3];
    gens = '{GATE_H, GATE_S, GATE_X};
    fail_count = 0;
    foreach (elem[i]) begin
      elem[i] = '0;
      word_len[i] = 0;
      for (int j = 0; j < 8; j++) word_gate[i][j] = 3'd0;
    end
    elem[0].img_x = 4'b0010;
    elem[0].img_z = 4'b0001;
    count = 1;
    for (int h = 0; h < count; h++)
      for (int j = 0; j < 3; j++) begin
        nf = fold_gate(elem[h], gens[j]);
        if (lookup_frame(nf, count) < 0 && count < GROUP_SIZE && word_len[h] < 8) begin
          elem[count] = nf;
          word_gate[count] = word_gate[h];
          word_gate[count][word_len[h]] = gens[j];
          word_len[count] = word_len[h] + 1;
          count++;
        end
      end
    for (int i = 0; i < GROUP_SIZE; i++)
      for (int g = 0; g < 6; g++)
        fold_tab[i][g] = 5'(lookup_frame(fold_gate(elem[i], g), GROUP_SIZE));
    foreach (frame_mirror[q]) frame_mirror[q] = 5'd0;
  end

  assign words_owed = owed_words.size();

  // Predict on every accepted input word.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      predict_item(opcode, wire_a, wire_b, gate_code, read_basis, read_flip);
  end

  // Compare every accepted result word with the oldest prediction.
  always @(posedge clk) begin
    result_word_t w;
    if (!rst && out_valid && !out_stall) begin
      if (owed_words.size() == 0) begin
        $error("result word with nothing predicted");
        fail_count++;
      end else begin
        w = owed_words.pop_front();
        if (emit_kind !== w.kind) begin
          $error("emit_kind expected %0d actual %0d", w.kind, emit_kind); fail_count++;
        end
        if (emit_gate !== w.gate) begin
          $error("emit_gate expected %0d actual %0d", w.gate, emit_gate); fail_count++;
        end
        if (emit_wire_a !== w.wa) begin
          $error("emit_wire_a expected %0d actual %0d", w.wa, emit_wire_a); fail_count++;
        end
        if (emit_wire_b !== w.wb) begin
          $error("emit_wire_b expected %0d actual %0d", w.wb, emit_wire_b); fail_count++;
        end
        if (emit_basis !== w.basis) begin
          $error("emit_basis expected %0d actual %0d", w.basis, emit_basis); fail_count++;
        end
        if (emit_flip !== w.flip) begin
          $error("emit_flip expected %0d actual %0d", w.flip, emit_flip); fail_count++;
        end
        if (last !== w.lst) begin
          $error("last expected %0d actual %0d", w.lst, last); fail_count++;
        end
      end
    end
  end

endmodule

// ===== tb/clifford_frame_tracker_test.sv =====
// Top of the Clifford frame tracker testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module clifford_frame_tracker_test
  import cft_pkg::*;
();

  localparam int IDLE_LIMIT = 5000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] opcode = '0;
  logic [7:0] wire_a = '0;
  logic [7:0] wire_b = '0;
  logic [2:0] gate_code = '0;
  logic [1:0] read_basis = '0;
  logic       read_flip = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] emit_kind;
  logic [2:0] emit_gate;
  logic [7:0] emit_wire_a;
  logic [7:0] emit_wire_b;
  logic [1:0] emit_basis;
  logic       emit_flip;
  logic       last;
  int         fail_count;
  int         words_owed;
  int         idle_cycles = 0;
  logic       send_burst = 1'b0;

  always #10 clk = ~clk;

  clifford_frame_tracker dut (.*);
  clifford_frame_tracker_check checker_i (.*);

  // Sends one word after a random gap; valid stays high across back-to-back words.
  task automatic send(logic [1:0] op, logic [7:0] a, logic [7:0] b, logic [2:0] g,
                      logic [1:0] rb, logic rf);
    int gap;
    logic st;
    gap = send_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    opcode <= op; wire_a <= a; wire_b <= b; gate_code <= g;
    read_basis <= rb; read_flip <= rf;
    in_valid <= 1'b1;
    do begin
      @(negedge clk);
      st = in_stall;
      @(posedge clk);
    end while (st);
  endtask

  function automatic logic [7:0] pick_wire();
    return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, 5));
  endfunction

  // Receiver: random stall before each result word, with stall-free stretches.
  initial begin
    int gap;
    logic v;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 29) == 0) send_burst = ~send_burst;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        v = out_valid;
        @(posedge clk);
      end while (!v);
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("clifford_frame_tracker test failed");
      $finish;
    end
  end

  initial begin
    int r;
    logic [1:0] op;
    logic [2:0] g;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed words: every gate, both entanglers, measurements, flushes, odd cases.
    send(OP_GATE1, 8'd0, 8'd0, 3'd0, 2'd0, 1'b0);
    send(OP_GATE1, 8'd0, 8'd0, 3'd1, 2'd0, 1'b0);
    send(OP_GATE1, 8'd1, 8'd0, 3'd2, 2'd0, 1'b0);
    send(OP_GATE1, 8'd1, 8'd0, 3'd3, 2'd0, 1'b0);
    send(OP_GATE1, 8'd2, 8'd0, 3'd4, 2'd0, 1'b0);
    send(OP_GATE1, 8'd2, 8'd0, 3'd5, 2'd0, 1'b0);
    send(OP_GATE2, 8'd0, 8'd1, GATE_CZ, 2'd0, 1'b0);
    send(OP_GATE2, 8'd1, 8'd2, GATE_CX, 2'd0, 1'b0);
    send(OP_GATE1, 8'd3, 8'd0, GATE_H, 2'd0, 1'b0);
    send(OP_GATE2, 8'd3, 8'd3, GATE_CX, 2'd0, 1'b0);
    send(OP_GATE2, 8'd3, 8'd3, GATE_CZ, 2'd0, 1'b0);
    send(OP_MEAS, 8'd0, 8'd0, 3'd0, 2'd0, 1'b1);
    send(OP_MEAS, 8'd1, 8'd0, 3'd0, 2'd1, 1'b0);
    send(OP_MEAS, 8'd2, 8'd0, 3'd0, BASIS_BAD, 1'b1);
    send(OP_GATE1, 8'd255, 8'd0, GATE_S, 2'd0, 1'b0);
    send(OP_GATE1, 8'd255, 8'd0, GATE_H, 2'd0, 1'b0);
    send(OP_FLUSH, 8'd255, 8'd0, 3'd0, 2'd0, 1'b0);
    send(OP_FLUSH, 8'd4, 8'd0, 3'd0, 2'd0, 1'b0);
    send(OP_GATE1, 8'd5, 8'd0, GATE_CX, 2'd0, 1'b0);
    send(OP_GATE2, 8'd5, 8'd6, 3'd2, 2'd0, 1'b0);
    send(OP_GATE2, 8'd255, 8'd0, GATE_CX, 2'd3, 1'b1);
    send(OP_FLUSH, 8'd2, 8'd255, 3'd7, 2'd3, 1'b1);

    // Random words: mostly well-formed on a few busy qubits, some mismatched noise.
    for (int n = 0; n < 108; n++) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        op = OP_GATE1; g = 3'($urandom_range(0, 5));
      end else if (r < 68) begin
        op = OP_GATE2; g = $urandom_range(0, 1) ? GATE_CX : GATE_CZ;
      end else if (r < 82) begin
        op = OP_MEAS; g = 3'($urandom_range(0, 7));
      end else if (r < 95) begin
        op = OP_FLUSH; g = 3'($urandom_range(0, 7));
      end else begin
        op = 2'($urandom_range(0, 1));
        g = (op == OP_GATE1) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      end
      send(op, pick_wire(), pick_wire(), g, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    end
    in_valid <= 1'b0;

    // Drain: wait for every predicted word, then a short tail for stray words.
    while (words_owed != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && words_owed == 0) begin
      $display("clifford_frame_tracker test passed");
    end else begin
      $display("clifford_frame_tracker test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/cft_pkg.sv
sv/cft_frame_mem.sv
sv/clifford_frame_tracker.sv
sv/cft_checker.sv
tb/clifford_frame_tracker_check.sv
tb/clifford_frame_tracker_test.sv
